// ===== rtl/fcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Fixed-length coin change count: shared package
// Types, register indexes and default sizes for the counting core.
// ----------------------------------------------------------------------------
`default_nettype none

package fcc_pkg;

  localparam int MAX_SUM_DEF   = 127;
  localparam int MAX_PARTS_DEF = 15;

  localparam int COUNT_W = 64;
  localparam int COIN_W  = 7;
  localparam int TSUM_W  = 7;
  localparam int PCNT_W  = 4;
  localparam int CFG_W   = 7;

  typedef enum logic [0:0] {
    CFG_TARGET_SUM = 1'b0,
    CFG_PART_COUNT = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FOLD,
    S_FEND,
    S_READ,
    S_RWAIT
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/fcc_ram.sv =====
// ----------------------------------------------------------------------------
// Fixed-length coin change count: generic RAM
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fcc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wa,
  input  wire logic [WIDTH-1:0]         wd,
  input  wire logic [$clog2(DEPTH)-1:0] ra_addr,
  input  wire logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic      [WIDTH-1:0]         ra_data,
  output logic      [WIDTH-1:0]         rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/fcc_sat_add.sv =====
// ----------------------------------------------------------------------------
// Fixed-length coin change count: saturating adder
// Unsigned add that clamps at all ones and flags the clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module fcc_sat_add #(
  parameter int WIDTH = 64
) (
  input  wire logic [WIDTH-1:0] a,
  input  wire logic [WIDTH-1:0] b,
  output logic      [WIDTH-1:0] sum,
  output logic                  sat
);

  logic [WIDTH:0] full;

  always_comb begin
    full = {1'b0, a} + {1'b0, b};
    sat  = full[WIDTH];
    sum  = full[WIDTH] ? {WIDTH{1'b1}} : full[WIDTH-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/fixed_length_coin_change_count_core.sv =====
// ----------------------------------------------------------------------------
// Fixed-length coin change count core
// Folds allowed part values into a table of partition counts, one table
// cell per cycle through a single saturating adder, and reports the count
// at the configured parts and target on the last item.
//
// Fold: a value v is folded by the one-cell-per-cycle table walk; a zero or
//   too-large value that is not last is skipped without a fold.
// Result: on a last item, the strobe is registered from S_RWAIT, after
//   S_READ; it is held for one cycle only; the receiver cannot stall it.
// Then the table is cleared, one entry a cycle: all (MAX_PARTS+1 rounded up
//   to a power of 2) x (MAX_SUM+1 rounded likewise) entries, 2048 at defaults.
// Reset runs the same clearing pass; busy is high meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_length_coin_change_count_core #(
  parameter int MAX_SUM   = fcc_pkg::MAX_SUM_DEF,
  parameter int MAX_PARTS = fcc_pkg::MAX_PARTS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [fcc_pkg::COIN_W-1:0]   coin_value,
  input  wire logic                         last_coin,
  input  wire logic                         cfg_we,
  input  wire fcc_pkg::cfg_idx_t            cfg_index,
  input  wire logic [fcc_pkg::CFG_W-1:0]    cfg_data,
  output logic                              result_valid,
  output logic      [fcc_pkg::COUNT_W-1:0]  partition_count,
  output logic                              overflowed
);

  import fcc_pkg::*;

  localparam int SW    = (MAX_SUM > 1) ? $clog2(MAX_SUM + 1) : 1;
  localparam int PW    = $clog2(MAX_PARTS + 1);
  localparam int AW    = PW + SW;
  localparam int DEPTH = 1 << AW;

  state_t state, state_next;

  logic [TSUM_W-1:0]  tsum;
  logic [PCNT_W-1:0]  pcnt;
  logic [SW-1:0]      coin_q;
  logic               last_q;
  logic [PW-1:0]      row;
  logic [SW-1:0]      col;
  logic [AW-1:0]      clr_addr;
  logic               p1_valid;
  logic [AW-1:0]      p1_addr;
  logic               sat_flag;

  logic               coin_skip;
  logic               in_range;
  logic [AW-1:0]      res_addr;
  logic               ram_we;
  logic [AW-1:0]      ram_wa;
  logic [COUNT_W-1:0] ram_wd;
  logic [AW-1:0]      ra_addr;
  logic [AW-1:0]      rb_addr;
  logic [COUNT_W-1:0] ra_data;
  logic [COUNT_W-1:0] rb_data;
  logic [COUNT_W-1:0] add_sum;
  logic               add_sat;

  assign busy      = (state != S_IDLE);
  assign coin_skip = (coin_value == '0) || (32'(coin_value) > MAX_SUM);
  assign in_range  = (32'(tsum) <= MAX_SUM) && (32'(pcnt) <= MAX_PARTS);
  assign res_addr  = {PW'(pcnt), SW'(tsum)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (!coin_skip) begin
            state_next = S_FOLD;
          end else if (last_coin) begin
            state_next = S_READ;
          end
        end
      end
      S_FOLD: begin
        if ((col == SW'(MAX_SUM)) && (row == PW'(MAX_PARTS))) begin
          state_next = S_FEND;
        end
      end
      S_FEND: begin
        state_next = last_q ? S_READ : S_IDLE;
      end
      S_READ: begin
        state_next = S_RWAIT;
      end
      S_RWAIT: begin
        state_next = S_CLEAR;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tsum <= '0;
      pcnt <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET_SUM: tsum <= cfg_data[TSUM_W-1:0];
        CFG_PART_COUNT: pcnt <= cfg_data[PCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer counters and fold pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr     <= '0;
      p1_valid     <= 1'b0;
      sat_flag     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      p1_valid     <= (state == S_FOLD);
      result_valid <= (state == S_RWAIT);
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (p1_valid && add_sat) begin
        sat_flag <= 1'b1;
      end
      if (state == S_RWAIT) begin
        clr_addr <= '0;
        sat_flag <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p1_addr <= {row, col};
    case (state)
      S_IDLE: begin
        coin_q <= SW'(coin_value);
        last_q <= last_coin;
        row    <= PW'(1);
        col    <= SW'(coin_value);
      end
      S_FOLD: begin
        if (col == SW'(MAX_SUM)) begin
          row <= row + PW'(1);
          col <= coin_q;
        end else begin
          col <= col + SW'(1);
        end
      end
      S_RWAIT: begin
        partition_count <= in_range ? ra_data : '0;
        overflowed      <= sat_flag;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ra_addr = (state == S_READ) ? res_addr : {row, col};
    rb_addr = {row - PW'(1), col - coin_q};
    ram_we  = p1_valid || (state == S_CLEAR);
    if (state == S_CLEAR) begin
      ram_wa = clr_addr;
      ram_wd = (clr_addr == '0) ? COUNT_W'(1) : '0;
    end else begin
      ram_wa = p1_addr;
      ram_wd = add_sum;
    end
  end

  fcc_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .wa      (ram_wa),
    .wd      (ram_wd),
    .ra_addr (ra_addr),
    .rb_addr (rb_addr),
    .ra_data (ra_data),
    .rb_data (rb_data)
  );

  fcc_sat_add #(
    .WIDTH (COUNT_W)
  ) u_add (
    .a   (ra_data),
    .b   (rb_data),
    .sum (add_sum),
    .sat (add_sat)
  );

  a_result_then_clear: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (state == S_CLEAR) && !sat_flag)
    else $error("result not followed by table clear");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !p1_valid)
    else $error("table write pending while idle");

  a_write_in_fold: assert property (@(posedge clk) disable iff (rst)
    p1_valid |-> (state == S_FOLD) || (state == S_FEND))
    else $error("fold write outside fold");

  a_fold_col_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_FOLD) |-> (col >= coin_q) && (row != '0))
    else $error("fold address out of range");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe longer than one cycle");

endmodule

`default_nettype wire
